>>> hw/rtl/lvw_pkg.sv
// shared types and constants of the lzw variable width encoder
package lvw_pkg;

	localparam int MAX_CODE_BITS = 12;
	localparam int ALPHABET_SIZE = 99;
	localparam int START_BITS    = 7;

	localparam int SYM_W   = 7;
	localparam int CODE_W  = MAX_CODE_BITS + 1;
	localparam int WIDTH_W = $clog2(MAX_CODE_BITS + 1);
	localparam int HASH_W  = MAX_CODE_BITS + 1;
	localparam int EPOCH_W = 8;
	localparam int BUF_W   = MAX_CODE_BITS + 8;
	localparam int CNT_W   = $clog2(BUF_W + 1);
	localparam int PAD_W   = 3;

	localparam logic [CODE_W-1:0]  FIRST_CODE  = CODE_W'(ALPHABET_SIZE + 1);
	localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(START_BITS);
	localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(MAX_CODE_BITS);

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} lvw_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_stream;
		logic       width_error;
	} lvw_out_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic [CODE_W-1:0]  prefix;
		logic [SYM_W-1:0]   sym;
		logic [CODE_W-1:0]  code;
	} lvw_entry_t;

	localparam int ENTRY_W = $bits(lvw_entry_t);

	typedef enum logic [1:0] {
		OP_CODE,
		OP_FLUSH,
		OP_ERR
	} lvw_op_t;

	typedef struct packed {
		lvw_op_t            op;
		logic [CODE_W-1:0]  value;
		logic [WIDTH_W-1:0] nbits;
	} lvw_cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WIDEN,
		ST_LOOKUP,
		ST_PROBE,
		ST_MISS,
		ST_POST,
		ST_FINAL,
		ST_FLUSH,
		ST_ERR
	} lvw_state_t;

endpackage

>>> hw/rtl/lzw_variable_width_encoder.sv
// top level of the lzw variable width encoder
// One symbol item is taken at a time. The first symbol of a stream only sets the prefix;
// any other goes through a lookup and a probe state, and on a miss through a state that
// emits the code and one that may widen the code; a widen state comes before the lookup
// when the code width grows, and the probe repeats for each extra hash probe in the
// dictionary ram. A last symbol ends with a state for the final code and one for the flush,
// which on a miss take the place of the state that may widen the code. The byte packer
// holds off each code while it drains full bytes, and longer while the receiver stalls. The
// dictionary is an open addressed hash table of 2^(MAX_CODE_BITS+1) entries, tagged with a
// stream epoch; after reset and after every 255 streams a clearing pass runs, taking no item.
module lzw_variable_width_encoder (
	input  logic              clk,
	input  logic              arst_n,
	input  lvw_pkg::lvw_in_t  in_data,
	input  logic              in_valid,
	output logic              in_ready,
	output lvw_pkg::lvw_out_t out_data,
	output logic              out_valid,
	input  logic              out_ready
);
	import lvw_pkg::*;

	lvw_state_t         state_q, state_d;
	logic [HASH_W-1:0]  clr_q;
	logic [HASH_W-1:0]  probe_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CODE_W-1:0]  prefix_q;
	logic [CODE_W-1:0]  next_q;
	logic [WIDTH_W-1:0] width_q;
	logic               started_q;
	logic               halted_q;
	logic [SYM_W-1:0]   sym_q;
	logic               last_q;

	lvw_cmd_t           cmd;
	logic               cmd_valid;
	logic               cmd_ready;
	logic               fire;
	logic               we;
	logic [HASH_W-1:0]  waddr;
	lvw_entry_t         wentry;
	logic [HASH_W-1:0]  raddr;
	logic [ENTRY_W-1:0] rbits;
	lvw_entry_t         rentry;
	logic [HASH_W-1:0]  hash_idx;
	logic               widen_due;
	logic               hit;
	logic               empty;
	logic               accept;

	assign rentry    = lvw_entry_t'(rbits);
	assign hash_idx  = HASH_W'(prefix_q) ^ (HASH_W'(sym_q) << (HASH_W - SYM_W));
	assign widen_due = next_q > (CODE_W'(1) << width_q);
	assign hit       = rentry.epoch == epoch_q && rentry.prefix == prefix_q &&
		rentry.sym == sym_q;
	assign empty     = rentry.epoch != epoch_q;
	assign fire      = cmd_valid && cmd_ready;
	assign accept    = in_valid && in_ready;

	lvw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(2 ** HASH_W)
	) u_dict (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(ENTRY_W'(wentry)),
		.raddr(raddr),
		.rdata(rbits)
	);

	lvw_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.out_data (out_data),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '{op: OP_CODE, value: '0, nbits: width_q};
		raddr     = (state_q == ST_PROBE) ? probe_q + HASH_W'(1) : hash_idx;
		we        = 1'b0;
		waddr     = clr_q;
		wentry    = '0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && !halted_q) begin
					if (!started_q) begin
						state_d = in_data.last ? ST_FINAL : ST_IDLE;
					end else if (widen_due) begin
						state_d = (width_q < MAX_WIDTH) ? ST_WIDEN : ST_ERR;
					end else begin
						state_d = ST_LOOKUP;
					end
				end
			end
			ST_WIDEN: begin
				cmd_valid = 1'b1;
				if (cmd_ready) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (hit) begin
					state_d = last_q ? ST_FINAL : ST_IDLE;
				end else if (empty) begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				cmd_valid = 1'b1;
				cmd.value = prefix_q;
				if (cmd_ready) begin
					we      = 1'b1;
					waddr   = probe_q;
					wentry  = '{epoch: epoch_q, prefix: prefix_q, sym: sym_q, code: next_q};
					state_d = last_q ? ST_FINAL : ST_POST;
				end
			end
			ST_POST: begin
				if (widen_due && width_q < MAX_WIDTH) begin
					cmd_valid = 1'b1;
					if (cmd_ready) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FINAL: begin
				cmd_valid = 1'b1;
				cmd.value = prefix_q;
				if (cmd_ready) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd_valid = 1'b1;
				cmd.op    = OP_FLUSH;
				if (cmd_ready) begin
					state_d = (epoch_q == '1) ? ST_CLEAR : ST_IDLE;
				end
			end
			ST_ERR: begin
				cmd_valid = 1'b1;
				cmd.op    = OP_ERR;
				if (cmd_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			epoch_q   <= '0;
			prefix_q  <= '0;
			next_q    <= FIRST_CODE;
			width_q   <= START_WIDTH;
			started_q <= 1'b0;
			halted_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + HASH_W'(1);
					if (clr_q == '1) begin
						epoch_q <= EPOCH_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept && !halted_q && !started_q) begin
						prefix_q  <= CODE_W'(in_data.symbol);
						started_q <= 1'b1;
					end
				end
				ST_WIDEN, ST_POST: begin
					if (fire) begin
						width_q <= width_q + WIDTH_W'(1);
					end
				end
				ST_LOOKUP: begin
					probe_q <= hash_idx;
				end
				ST_PROBE: begin
					if (hit) begin
						prefix_q <= rentry.code;
					end else if (!empty) begin
						probe_q <= probe_q + HASH_W'(1);
					end
				end
				ST_MISS: begin
					if (fire) begin
						next_q   <= next_q + CODE_W'(1);
						prefix_q <= CODE_W'(sym_q);
					end
				end
				ST_FLUSH: begin
					if (fire) begin
						prefix_q  <= '0;
						next_q    <= FIRST_CODE;
						width_q   <= START_WIDTH;
						started_q <= 1'b0;
						epoch_q   <= epoch_q + EPOCH_W'(1);
					end
				end
				ST_ERR: begin
					if (fire) begin
						halted_q <= 1'b1;
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= in_data.symbol;
			last_q <= in_data.last;
		end
	end

endmodule

>>> hw/rtl/lvw_ram.sv
// generic single write port ram with registered read
module lvw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/lvw_packer.sv
// bit packer: appends codes msb first, emits bytes, padding and end bytes
module lvw_packer (
	input  logic              clk,
	input  logic              arst_n,
	input  lvw_pkg::lvw_cmd_t cmd,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	output lvw_pkg::lvw_out_t out_data,
	output logic              out_valid,
	input  logic              out_ready
);
	import lvw_pkg::*;

	logic [BUF_W-1:0] buf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             eos_pend_q;
	logic [PAD_W-1:0] pad_q;
	logic             out_valid_q;
	lvw_out_t         out_q;
	logic             slot_free;
	logic             have_byte;
	logic             load_out;
	logic [BUF_W-1:0] emit_word;
	logic [BUF_W-1:0] pad_word;
	logic [BUF_W-1:0] code_bits;
	logic [CODE_W-1:0] code_mask;

	assign slot_free = !out_valid_q || out_ready;
	assign have_byte = cnt_q >= CNT_W'(8);
	assign emit_word = buf_q >> (cnt_q - CNT_W'(8));
	assign pad_word  = buf_q << (CNT_W'(8) - cnt_q);
	assign code_mask = ~({CODE_W{1'b1}} << cmd.nbits);
	assign code_bits = BUF_W'(cmd.value & code_mask);

	assign cmd_ready = !have_byte && !eos_pend_q && (cmd.op == OP_CODE || slot_free);
	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	// a new item enters the output register this cycle
	assign load_out = slot_free && (have_byte || eos_pend_q ||
		(cmd_valid && cmd_ready && (cmd.op inside {OP_FLUSH, OP_ERR})));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			eos_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (have_byte) begin
				if (slot_free) begin
					out_q       <= '{out_byte: emit_word[7:0], end_of_stream: 1'b0,
						width_error: 1'b0};
					cnt_q       <= cnt_q - CNT_W'(8);
				end
			end else if (eos_pend_q) begin
				if (slot_free) begin
					out_q       <= '{out_byte: 8'(pad_q), end_of_stream: 1'b1,
						width_error: 1'b0};
					eos_pend_q  <= 1'b0;
				end
			end else if (cmd_valid && cmd_ready) begin
				case (cmd.op)
					OP_CODE: begin
						buf_q <= (buf_q << cmd.nbits) | code_bits;
						cnt_q <= cnt_q + CNT_W'(cmd.nbits);
					end
					OP_FLUSH: begin
						if (cnt_q != '0) begin
							out_q      <= '{out_byte: pad_word[7:0], end_of_stream: 1'b0,
								width_error: 1'b0};
							pad_q      <= PAD_W'(CNT_W'(8) - cnt_q);
							eos_pend_q <= 1'b1;
						end else begin
							out_q <= '{out_byte: 8'd0, end_of_stream: 1'b1, width_error: 1'b0};
						end
						cnt_q <= '0;
					end
					OP_ERR: begin
						out_q       <= '{out_byte: 8'd0, end_of_stream: 1'b0, width_error: 1'b1};
						cnt_q       <= '0;
					end
					default: begin
						cnt_q <= cnt_q;
					end
				endcase
			end
		end
	end

endmodule

>>> verif/tb.sv
// testbench for the lzw variable width encoder: predicted byte stream checked item by item
module tb;
	import lvw_pkg::*;

	localparam int MAX_CYCLES = 200000;
	localparam int SLOTS = (1 << MAX_CODE_BITS) + 1;

	logic     clk;
	logic     arst_n;
	lvw_in_t  in_data;
	logic     in_valid;
	logic     in_ready;
	lvw_out_t out_data;
	logic     out_valid;
	logic     out_ready;

	lzw_variable_width_encoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
	);

	// encoder state as predicted
	int       dict_pfx [SLOTS];
	int       dict_sym [SLOTS];
	int       pfx_code;
	int       nxt_code;
	int       cur_width;
	bit [7:0] acc_byte;
	int       acc_bits;
	bit       started;
	bit       stopped;

	lvw_out_t byte_q [$];
	int       errors;
	int       cycles;
	int       n_items;
	int       n_bytes;
	int       n_streams;
	bit       idle_on;
	int       hold_cycles;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// receiver side
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (!idle_on)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= 37);
	end

	task automatic report(string what, lvw_out_t got, lvw_out_t want);
		errors++;
		$display("mismatch %s: got %h/%b/%b want %h/%b/%b", what,
			got.out_byte, got.end_of_stream, got.width_error,
			want.out_byte, want.end_of_stream, want.width_error);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			lvw_out_t want;
			n_bytes++;
			if (byte_q.size() == 0)
				report("unexpected item", out_data, '0);
			else begin
				want = byte_q.pop_front();
				if (out_data.out_byte != want.out_byte)
					report("out_byte", out_data, want);
				if (out_data.end_of_stream != want.end_of_stream)
					report("end_of_stream", out_data, want);
				if (out_data.width_error != want.width_error)
					report("width_error", out_data, want);
			end
		end
	end

	function automatic void push_byte(bit [7:0] b, bit eos, bit err);
		lvw_out_t r;
		r.out_byte = b;
		r.end_of_stream = eos;
		r.width_error = err;
		byte_q = {byte_q, r};
	endfunction

	function automatic void pack_code(int value, int nbits);
		for (int k = nbits; k > 0; k--) begin
			acc_byte = {acc_byte[6:0], 1'(value >> (k - 1))};
			acc_bits++;
			if (acc_bits == 8) begin
				push_byte(acc_byte, 1'b0, 1'b0);
				acc_byte = '0;
				acc_bits = 0;
			end
		end
	endfunction

	function automatic void new_stream();
		pfx_code = 0;
		nxt_code = ALPHABET_SIZE + 1;
		cur_width = START_BITS;
		acc_byte = '0;
		acc_bits = 0;
		started = 1'b0;
	endfunction

	function automatic void encode_symbol(int sym, bit last);
		int  c;
		int  pad;
		bit  hit;
		if (stopped)
			return;
		if (!started) begin
			pfx_code = sym;
			started = 1'b1;
		end else begin
			hit = 1'b0;
			if (nxt_code > (1 << cur_width)) begin
				if (cur_width < MAX_CODE_BITS) begin
					pack_code(0, cur_width);
					cur_width++;
				end else begin
					stopped = 1'b1;
					push_byte(8'h00, 1'b0, 1'b1);
					return;
				end
			end
			for (c = ALPHABET_SIZE + 1; c < nxt_code && c < SLOTS; c++)
				if (dict_pfx[c] == pfx_code && dict_sym[c] == sym) begin
					hit = 1'b1;
					break;
				end
			if (hit)
				pfx_code = c;
			else begin
				pack_code(pfx_code, cur_width);
				if (nxt_code < SLOTS) begin
					dict_pfx[nxt_code] = pfx_code;
					dict_sym[nxt_code] = sym;
				end
				nxt_code++;
				pfx_code = sym;
				if (!last && nxt_code > (1 << cur_width) && cur_width < MAX_CODE_BITS) begin
					pack_code(0, cur_width);
					cur_width++;
				end
			end
		end
		if (last) begin
			pad = 0;
			pack_code(pfx_code, cur_width);
			if (acc_bits != 0) begin
				pad = 8 - acc_bits;
				push_byte(8'(acc_byte << pad), 1'b0, 1'b0);
			end
			push_byte(8'(pad), 1'b1, 1'b0);
			new_stream();
			n_streams++;
		end
	endfunction

	task automatic send_item(int sym, bit last);
		if (idle_on && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		encode_symbol(sym, last);
		in_data.symbol <= 7'(sym);
		in_data.last <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		n_items++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (byte_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic int pick_symbol(int alpha);
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return $urandom_range(127, 100);
		if (r < 6)
			return 0;
		return $urandom_range(alpha, 1);
	endfunction

	task automatic test_directed();
		int seq [] = '{1, 2, 1, 2, 1, 2, 1, 2, 1};
		send_item(1, 1'b1);
		send_item(99, 1'b1);
		send_item(0, 1'b1);
		send_item(127, 1'b1);
		foreach (seq[i])
			send_item(seq[i], i == seq.size() - 1);
		send_item(0, 1'b0);
		send_item(0, 1'b0);
		send_item(100, 1'b0);
		send_item(85, 1'b0);
		send_item(42, 1'b1);
		drain();
	endtask

	task automatic test_random(int count);
		int len;
		int alpha;
		int sent;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(20, 1);
			alpha = ($urandom_range(1) == 0) ? $urandom_range(6, 2) : 99;
			for (int i = 0; i < len; i++)
				send_item(pick_symbol(alpha), i == len - 1);
			sent += len;
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int i = 0; i < 40; i++)
			send_item(pick_symbol(99), i == 39);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		errors = 0;
		cycles = 0;
		n_items = 0;
		n_bytes = 0;
		n_streams = 0;
		hold_cycles = 0;
		idle_on = 1'b1;
		stopped = 1'b0;
		new_stream();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(100);
		idle_on = 1'b0;
		test_random(50);
		idle_on = 1'b1;
		test_random(110);
		test_backpressure();
		$display("%0d symbols in %0d completed streams, %0d output items, with idling and a long stall",
			n_items, n_streams, n_bytes);
		$display("%0d mismatches, %0d cycles", errors, cycles);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/lvw_pkg.sv
hw/rtl/lvw_ram.sv
hw/rtl/lvw_packer.sv
hw/rtl/lzw_variable_width_encoder.sv
verif/tb.sv
